FILE: hdl/ifd_pkg.sv
// Shared types and codes for the information frame deframer.
`default_nettype none
package ifd_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_DUP  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_FLAG     = 3'd0,
    CFG_ESCAPE   = 3'd1,
    CFG_FLAG_SUB = 3'd2,
    CFG_ESC_SUB  = 3'd3,
    CFG_ADDRESS  = 3'd4,
    CFG_CTRL0    = 3'd5,
    CFG_CTRL1    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       frame_end;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/info_frame_deframer.sv
// Receive-side deframer: flag hunt, header check, destuffing and BCC2 check.
//
// Input channel: rx_valid_i / rx_stall_o carry one received byte per item.
// Output channel: res_valid_o / res_stall_i carry at most one result per
// byte: a destuffed payload byte (released one byte late, so BCC2 is never
// passed on) or a frame status on the closing flag (good, check error,
// duplicate) with frame_end_o set.
// One byte is accepted every cycle while rx_stall_o is low. The frame state
// updates when the byte is taken, and its result is loaded into the output
// register at the same edge. A result that cannot leave because the receiver
// stalls moves to a one-entry skid register; rx_stall_o is high only while
// the skid entry is full, so a receiver stall reaches the sender through it.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i at once;
// indexes beyond the list are ignored. Write only while the block is idle.
// Reset (rst_ni low, asynchronous) restores the register defaults, puts the
// block back to hunting for an opening flag with expected sequence zero,
// and empties the output and skid registers.
`default_nettype none
module info_frame_deframer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       rx_valid_i,
  output logic            rx_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            res_valid_o,
  input  wire logic       res_stall_i,
  output logic [1:0]      result_kind_o,
  output logic [7:0]      payload_byte_o,
  output logic            frame_end_o
);

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_FLAG  = 3'd1;
  localparam logic [2:0] PH_ADDR  = 3'd2;
  localparam logic [2:0] PH_CTRL  = 3'd3;
  localparam logic [2:0] PH_DATA0 = 3'd4;
  localparam logic [2:0] PH_DUP   = 3'd5;
  localparam logic [2:0] PH_DATA  = 3'd6;

  logic [7:0] flag_q, esc_q, flag_sub_q, esc_sub_q, addr_q, ctrl0_q, ctrl1_q;

  logic [2:0] phase_q, phase_d;
  logic       seq_q, seq_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] held_q, held_d;
  logic       held_vld_q, held_vld_d;
  logic       esc_pend_q, esc_pend_d;

  logic             out_valid_q, skid_valid_q;
  ifd_pkg::result_t out_q, skid_q;

  logic             rx_acc, out_take;
  logic             res_vld;
  ifd_pkg::result_t res;
  logic [7:0]       want, other;

  assign rx_acc   = rx_valid_i && !rx_stall_o;
  assign out_take = out_valid_q && !res_stall_i;
  assign want     = seq_q ? ctrl1_q : ctrl0_q;
  assign other    = seq_q ? ctrl0_q : ctrl1_q;

  always_comb begin
    logic           take, close, ok;
    logic [7:0]     take_byte;
    ifd_pkg::kind_e close_kind;
    take       = 1'b0;
    close      = 1'b0;
    ok         = 1'b0;
    take_byte  = rx_byte_i;
    close_kind = ifd_pkg::KIND_ERR;
    phase_d    = phase_q;
    seq_d      = seq_q;
    acc_d      = acc_q;
    held_d     = held_q;
    held_vld_d = held_vld_q;
    esc_pend_d = esc_pend_q;
    res_vld    = 1'b0;
    res        = '{kind: ifd_pkg::KIND_DATA, data: 8'd0, frame_end: 1'b0};
    case (phase_q)
      PH_FLAG: begin
        if (rx_byte_i == addr_q) phase_d = PH_ADDR;
        else if (rx_byte_i != flag_q) phase_d = PH_HUNT;
      end
      PH_ADDR: begin
        if (rx_byte_i == want) phase_d = PH_CTRL;
        else if (rx_byte_i == other) phase_d = PH_DUP;
        else if (rx_byte_i == flag_q) phase_d = PH_FLAG;
        else phase_d = PH_HUNT;
      end
      PH_CTRL: begin
        if (rx_byte_i == (want ^ addr_q)) begin
          phase_d    = PH_DATA0;
          acc_d      = rx_byte_i;
          held_vld_d = 1'b0;
          esc_pend_d = 1'b0;
        end else if (rx_byte_i == flag_q) begin
          phase_d = PH_FLAG;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_DUP: begin
        if (rx_byte_i == flag_q) begin
          close      = 1'b1;
          close_kind = ifd_pkg::KIND_DUP;
        end
      end
      PH_DATA0, PH_DATA: begin
        if (esc_pend_q) begin
          esc_pend_d = 1'b0;
          if (rx_byte_i == flag_q) begin
            close = 1'b1;
          end else if (rx_byte_i == flag_sub_q) begin
            take      = 1'b1;
            take_byte = flag_q;
          end else if (rx_byte_i == esc_sub_q) begin
            take      = 1'b1;
            take_byte = esc_q;
          end
        end else if (rx_byte_i == flag_q) begin
          ok         = (phase_q == PH_DATA) && held_vld_q && (acc_q == held_q);
          close      = 1'b1;
          close_kind = ok ? ifd_pkg::KIND_GOOD : ifd_pkg::KIND_ERR;
          if (ok) seq_d = ~seq_q;
        end else if (rx_byte_i == esc_q) begin
          esc_pend_d = 1'b1;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        phase_d = (rx_byte_i == flag_q) ? PH_FLAG : PH_HUNT;
      end
    endcase
    if (take) begin
      if (held_vld_q) begin
        res_vld  = 1'b1;
        res.data = held_q;
        acc_d    = acc_q ^ held_q;
        phase_d  = PH_DATA;
      end
      held_d     = take_byte;
      held_vld_d = 1'b1;
    end
    if (close) begin
      phase_d       = PH_FLAG;
      held_vld_d    = 1'b0;
      esc_pend_d    = 1'b0;
      res_vld       = 1'b1;
      res.kind      = close_kind;
      res.frame_end = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q     <= 8'd126;
      esc_q      <= 8'd125;
      flag_sub_q <= 8'd94;
      esc_sub_q  <= 8'd93;
      addr_q     <= 8'd3;
      ctrl0_q    <= 8'd0;
      ctrl1_q    <= 8'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ifd_pkg::CFG_FLAG:     flag_q     <= cfg_data_i;
        ifd_pkg::CFG_ESCAPE:   esc_q      <= cfg_data_i;
        ifd_pkg::CFG_FLAG_SUB: flag_sub_q <= cfg_data_i;
        ifd_pkg::CFG_ESC_SUB:  esc_sub_q  <= cfg_data_i;
        ifd_pkg::CFG_ADDRESS:  addr_q     <= cfg_data_i;
        ifd_pkg::CFG_CTRL0:    ctrl0_q    <= cfg_data_i;
        ifd_pkg::CFG_CTRL1:    ctrl1_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      seq_q      <= 1'b0;
      acc_q      <= 8'd0;
      held_q     <= 8'd0;
      held_vld_q <= 1'b0;
      esc_pend_q <= 1'b0;
    end else if (rx_acc) begin
      phase_q    <= phase_d;
      seq_q      <= seq_d;
      acc_q      <= acc_d;
      held_q     <= held_d;
      held_vld_q <= held_vld_d;
      esc_pend_q <= esc_pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_q        <= skid_q;
        skid_valid_q <= 1'b0;
      end
    end else if (rx_acc && res_vld) begin
      if (!out_valid_q || out_take) begin
        out_q       <= res;
        out_valid_q <= 1'b1;
      end else begin
        skid_q       <= res;
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rx_stall_o     = skid_valid_q;
  assign res_valid_o    = out_valid_q;
  assign result_kind_o  = out_q.kind;
  assign payload_byte_o = out_q.data;
  assign frame_end_o    = out_q.frame_end;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && res_stall_i))
    else $error("skid filled without a stalled output");

  a_end_marks_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (frame_end_o == (out_q.kind != ifd_pkg::KIND_DATA)))
    else $error("frame_end does not match result kind");

  a_status_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && frame_end_o) |-> (payload_byte_o == 8'd0))
    else $error("status result carries a payload byte");

endmodule
`default_nettype wire

FILE: verif/info_frame_deframer_test.sv
// Self-checking testbench for info_frame_deframer: directed and random frames over several register settings.
`default_nettype none
module info_frame_deframer_test;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_FLAG  = 3'd1,
    PH_ADDR  = 3'd2,
    PH_CTRL  = 3'd3,
    PH_DATA0 = 3'd4,
    PH_DUP   = 3'd5,
    PH_DATA  = 3'd6
  } rx_phase_e;

  typedef enum int unsigned {
    FR_GOOD,
    FR_BAD_BCC,
    FR_DUP,
    FR_EMPTY,
    FR_ESC_FLAG,
    FR_BAD_HDR,
    FR_NOISE
  } frame_style_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic       rx_valid_i = 1'b0;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i = '0;
  logic       res_valid_o;
  logic       res_stall_i = 1'b0;
  logic [1:0] result_kind_o;
  logic [7:0] payload_byte_o;
  logic       frame_end_o;

  // predictor copy of the registers and the frame state
  logic [7:0] flag_v = 8'h7E;
  logic [7:0] esc_v = 8'h7D;
  logic [7:0] flag_sub_v = 8'h5E;
  logic [7:0] esc_sub_v = 8'h5D;
  logic [7:0] addr_v = 8'h03;
  logic [7:0] ctrl0_v = 8'h00;
  logic [7:0] ctrl1_v = 8'h40;
  rx_phase_e  rx_phase = PH_HUNT;
  logic       seq_bit = 1'b0;
  logic [7:0] bcc_acc = 8'h00;
  logic [7:0] held_byte = 8'h00;
  logic       held_valid = 1'b0;
  logic       esc_pending = 1'b0;

  ifd_pkg::result_t deframed_q[$];
  logic [7:0]  frame_bytes[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_count = 0;
  int unsigned stall_left = 0;
  bit          gaps_on = 1'b1;

  info_frame_deframer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .rx_valid_i    (rx_valid_i),
    .rx_stall_o    (rx_stall_o),
    .rx_byte_i     (rx_byte_i),
    .res_valid_o   (res_valid_o),
    .res_stall_i   (res_stall_i),
    .result_kind_o (result_kind_o),
    .payload_byte_o(payload_byte_o),
    .frame_end_o   (frame_end_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      res_stall_i <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    ifd_pkg::result_t exp_res;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (deframed_q.size() == 0) begin
        $error("unexpected result: kind %0d byte %0h end %0b",
               result_kind_o, payload_byte_o, frame_end_o);
        error_count++;
      end else begin
        exp_res = deframed_q.pop_front();
        if (result_kind_o !== exp_res.kind) begin
          $error("result_kind: expected %0d, got %0d", exp_res.kind, result_kind_o);
          error_count++;
        end
        if (payload_byte_o !== exp_res.data) begin
          $error("payload_byte: expected %0h, got %0h", exp_res.data, payload_byte_o);
          error_count++;
        end
        if (frame_end_o !== exp_res.frame_end) begin
          $error("frame_end: expected %0b, got %0b", exp_res.frame_end, frame_end_o);
          error_count++;
        end
      end
    end
  end

  function automatic void finish_frame(input ifd_pkg::kind_e kind);
    ifd_pkg::result_t r;
    r.kind = kind;
    r.data = 8'h00;
    r.frame_end = 1'b1;
    deframed_q.push_back(r);
    rx_phase = PH_FLAG;
    held_valid = 1'b0;
    esc_pending = 1'b0;
  endfunction

  // data leaves one byte late so the trailing BCC2 is never passed on
  function automatic void take_payload(input logic [7:0] d);
    ifd_pkg::result_t r;
    if (held_valid) begin
      r.kind = ifd_pkg::KIND_DATA;
      r.data = held_byte;
      r.frame_end = 1'b0;
      deframed_q.push_back(r);
      bcc_acc = bcc_acc ^ held_byte;
      rx_phase = PH_DATA;
    end
    held_byte = d;
    held_valid = 1'b1;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0] want_ctrl;
    logic [7:0] other_ctrl;
    logic       good;
    want_ctrl = seq_bit ? ctrl1_v : ctrl0_v;
    other_ctrl = seq_bit ? ctrl0_v : ctrl1_v;
    case (rx_phase)
      PH_FLAG: begin
        if (b == addr_v) rx_phase = PH_ADDR;
        else if (b != flag_v) rx_phase = PH_HUNT;
      end
      PH_ADDR: begin
        if (b == want_ctrl) rx_phase = PH_CTRL;
        else if (b == other_ctrl) rx_phase = PH_DUP;
        else if (b == flag_v) rx_phase = PH_FLAG;
        else rx_phase = PH_HUNT;
      end
      PH_CTRL: begin
        if (b == (want_ctrl ^ addr_v)) begin
          rx_phase = PH_DATA0;
          bcc_acc = b;
          held_valid = 1'b0;
          esc_pending = 1'b0;
        end else if (b == flag_v) begin
          rx_phase = PH_FLAG;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_DUP: begin
        if (b == flag_v) finish_frame(ifd_pkg::KIND_DUP);
      end
      PH_DATA0, PH_DATA: begin
        if (esc_pending) begin
          esc_pending = 1'b0;
          if (b == flag_v) finish_frame(ifd_pkg::KIND_ERR);
          else if (b == flag_sub_v) take_payload(flag_v);
          else if (b == esc_sub_v) take_payload(esc_v);
        end else if (b == flag_v) begin
          good = (rx_phase == PH_DATA) && held_valid && (bcc_acc == held_byte);
          if (good) seq_bit = ~seq_bit;
          finish_frame(good ? ifd_pkg::KIND_GOOD : ifd_pkg::KIND_ERR);
        end else if (b == esc_v) begin
          esc_pending = 1'b1;
        end else begin
          take_payload(b);
        end
      end
      default: rx_phase = (b == flag_v) ? PH_FLAG : PH_HUNT;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    deframe_byte(b);
    rx_count++;
  endtask

  task automatic send_queued();
    int unsigned i;
    for (i = 0; i < frame_bytes.size(); i++) send_byte(frame_bytes[i]);
  endtask

  task automatic drain();
    rx_valid_i <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ifd_pkg::CFG_FLAG:     flag_v = v;
      ifd_pkg::CFG_ESCAPE:   esc_v = v;
      ifd_pkg::CFG_FLAG_SUB: flag_sub_v = v;
      ifd_pkg::CFG_ESC_SUB:  esc_sub_v = v;
      ifd_pkg::CFG_ADDRESS:  addr_v = v;
      ifd_pkg::CFG_CTRL0:    ctrl0_v = v;
      ifd_pkg::CFG_CTRL1:    ctrl1_v = v;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] f, input logic [7:0] e, input logic [7:0] fs,
                            input logic [7:0] es, input logic [7:0] a,
                            input logic [7:0] c0, input logic [7:0] c1);
    drain();
    write_reg(ifd_pkg::CFG_FLAG, f);
    write_reg(ifd_pkg::CFG_ESCAPE, e);
    write_reg(ifd_pkg::CFG_FLAG_SUB, fs);
    write_reg(ifd_pkg::CFG_ESC_SUB, es);
    write_reg(ifd_pkg::CFG_ADDRESS, a);
    write_reg(ifd_pkg::CFG_CTRL0, c0);
    write_reg(ifd_pkg::CFG_CTRL1, c1);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return flag_v;
      1: return esc_v;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void stuff_byte(input logic [7:0] d);
    if (d == flag_v) begin
      frame_bytes.push_back(esc_v);
      frame_bytes.push_back(flag_sub_v);
    end else if (d == esc_v) begin
      frame_bytes.push_back(esc_v);
      frame_bytes.push_back(esc_sub_v);
    end else begin
      frame_bytes.push_back(d);
    end
  endfunction

  task automatic send_frame(input frame_style_e style);
    logic [7:0]  ctrl;
    logic [7:0]  acc;
    logic [7:0]  d;
    int unsigned len;
    int unsigned i;
    int unsigned pos;
    frame_bytes.delete();
    if (style == FR_NOISE) begin
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++) frame_bytes.push_back(pick_byte());
      send_queued();
      return;
    end
    // close whatever is left open so the header lands in a known phase
    if (rx_phase != PH_HUNT && rx_phase != PH_FLAG) send_byte(flag_v);
    if (rx_phase == PH_HUNT || $urandom_range(0, 1)) frame_bytes.push_back(flag_v);
    ctrl = (seq_bit ^ (style == FR_DUP)) ? ctrl1_v : ctrl0_v;
    frame_bytes.push_back(addr_v);
    frame_bytes.push_back(ctrl);
    frame_bytes.push_back(ctrl ^ addr_v);
    if (style == FR_BAD_HDR) begin
      pos = $urandom_range(frame_bytes.size() - 3, frame_bytes.size() - 1);
      frame_bytes[pos] = $urandom_range(0, 1) ? flag_v : 8'($urandom_range(0, 255));
    end
    if (style == FR_EMPTY) len = 0;
    else if ($urandom_range(0, 15) == 0) len = $urandom_range(9, 24);
    else len = $urandom_range(1, 8);
    acc = ctrl ^ addr_v;
    for (i = 0; i < len; i++) begin
      d = pick_byte();
      acc = acc ^ d;
      stuff_byte(d);
      if ($urandom_range(0, 19) == 0) begin
        d = 8'($urandom_range(0, 255));
        if (d != flag_v && d != flag_sub_v && d != esc_sub_v) begin
          frame_bytes.push_back(esc_v);
          frame_bytes.push_back(d);
        end
      end
    end
    case (style)
      FR_BAD_BCC: begin
        d = 8'($urandom_range(1, 255));
        stuff_byte(acc ^ d);
      end
      FR_EMPTY: begin
        if ($urandom_range(0, 1)) stuff_byte(acc);
      end
      FR_ESC_FLAG: frame_bytes.push_back(esc_v);
      default: stuff_byte(acc);
    endcase
    frame_bytes.push_back(flag_v);
    send_queued();
  endtask

  task automatic run_random(input int unsigned n_bytes);
    int unsigned  stop_at;
    int unsigned  pick;
    frame_style_e style;
    stop_at = rx_count + n_bytes;
    while (rx_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) style = FR_GOOD;
      else if (pick < 60) style = FR_BAD_BCC;
      else if (pick < 68) style = FR_DUP;
      else if (pick < 74) style = FR_EMPTY;
      else if (pick < 80) style = FR_ESC_FLAG;
      else if (pick < 90) style = FR_BAD_HDR;
      else style = FR_NOISE;
      send_frame(style);
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  // reset register values
  task automatic test_directed_frames();
    // good frame: extremes, both stuffed pairs, an unknown escape pair
    frame_bytes = '{8'h7E, 8'h03, 8'h00, 8'h03, 8'hFF, 8'h7D, 8'h5E, 8'h7D, 8'h5D,
                    8'h7D, 8'h11, 8'h00, 8'hFF, 8'h7E,
                    // shared flag, old sequence: duplicate
                    8'h03, 8'h00, 8'h55, 8'h7E,
                    // flag in place of control, then a frame with no payload
                    8'h03, 8'h7E, 8'h03, 8'h40, 8'h43, 8'h7E,
                    // flag right after escape
                    8'h03, 8'h40, 8'h43, 8'h12, 8'h7D, 8'h7E};
    send_queued();
  endtask

  task automatic test_random_frames();
    run_random(250);
  endtask

  task automatic test_moved_codes();
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    run_random(250);
  endtask

  task automatic test_extreme_codes();
    set_config(8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF, 8'h00, 8'hFF);
    run_random(200);
  endtask

  // flag equals escape, equal substitutes, equal control codes
  task automatic test_shared_codes();
    set_config(8'h7E, 8'h7E, 8'h5E, 8'h5E, 8'h03, 8'h11, 8'h11);
    write_reg(CFG_UNUSED, 8'hA5);
    run_random(200);
  endtask

  task automatic test_steady_stream();
    gaps_on = 1'b0;
    set_config(8'h7E, 8'h7D, 8'h5E, 8'h5D, 8'h03, 8'h00, 8'h40);
    run_random(200);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_frames();
    test_random_frames();
    test_moved_codes();
    test_extreme_codes();
    test_shared_codes();
    test_steady_stream();
    drain();
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire
